### src/dpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants
// Field widths, fixed-point constants and the configuration bundle of the
// depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

   // pipeline depth
   localparam int NUM_STAGES = 6;

   // field widths
   localparam int COL_W   = 12;
   localparam int RAW_W   = 32;
   localparam int ROT_W   = 16;
   localparam int TRANS_W = 21;
   localparam int PP_W    = 14;
   localparam int OUT_W   = 24;

   // internal widths
   localparam int DEPTH_W = 19;               // Q3.16 metres
   localparam int DIFF_W  = 16;               // 2u - cx
   localparam int NUM_W   = 35;               // (2u - cx) * d, signed
   localparam int MAG_W   = 34;               // |num| + 525
   localparam int QUO_W   = 24;               // |num| / 1050
   localparam int PNT_W   = QUO_W + 1;        // camera point, signed
   localparam int PROD_W  = ROT_W + PNT_W;    // rotation product
   localparam int ACC_W   = 46;               // world accumulator
   localparam int FRAC_SHIFT = 20;            // Q.30 -> Q.10

   // millimetre depth: kept strictly between these, then * 65536 / 1000
   localparam logic [15:0] MM_LOW   = 16'd200;
   localparam logic [15:0] MM_HIGH  = 16'd5000;
   localparam int          MM_NUM_W = 29;
   localparam logic [MM_NUM_W-1:0] MM_ROUND = 29'd500;
   localparam logic [29:0] MM_RECIP = 30'd549755814;   // ceil(2^39 / 1000)
   localparam int          MM_SHIFT = 39;
   localparam int          MM_PROD_W = MM_NUM_W + 30;

   // float depth: bit patterns of 0.2f and 5.0f, exponent giving shift 0
   localparam logic [RAW_W-1:0] F32_LOW   = 32'h3E4C_CCCD;
   localparam logic [RAW_W-1:0] F32_HIGH  = 32'h40A0_0000;
   localparam logic [7:0]       F32_SHIFT_BASE = 8'd134;

   // rounded division by 2 * focal length
   localparam logic [10:0] DIV_CONST = 11'd1050;
   localparam logic [9:0]  DIV_HALF  = 10'd525;
   localparam logic [29:0] DIV_RECIP = 30'd1047153931;  // floor(2^40 / 1050)
   localparam int          DIV_SHIFT = 30;
   localparam int          EST_W     = QUO_W + 30;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_SHIFT - 1));
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_ROT_ROW_0   = 3'd0,
      CSR_ROT_ROW_1   = 3'd1,
      CSR_ROT_ROW_2   = 3'd2,
      CSR_TRANSLATION = 3'd3,
      CSR_PRINCIPAL   = 3'd4,
      CSR_DEPTH_FMT   = 3'd5,
      CSR_POSE_VALID  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [2:0][2:0][ROT_W-1:0] rot;     // [row][col], Q1.14
      logic [2:0][TRANS_W-1:0]    trans;   // 1/1024 m
      logic [PP_W-1:0]            cy;      // half pixels
      logic [PP_W-1:0]            cx;
      logic                       depth_fmt;
      logic                       pose_valid;
   } cfg_type;

endpackage

### src/dpw_depth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_depth: depth decode and camera numerators
// Stage 0 converts millimetres or float metres to Q3.16 and forms 2u - cx,
// 2v - cy; stage 1 multiplies them by the depth.
// ----------------------------------------------------------------------------
module dpw_depth
   import dpw_pkg::*;
(
   input  logic                    clock,
   input  logic [1:0]              adv,
   input  cfg_type                 cfg,
   input  logic [COL_W-1:0]        col,
   input  logic [COL_W-1:0]        row,
   input  logic [RAW_W-1:0]        depth_raw,
   output logic                    keep,
   output logic signed [NUM_W-1:0] num_x,
   output logic signed [NUM_W-1:0] num_y,
   output logic [DEPTH_W-1:0]      depth
);

   logic [15:0]          mm;
   logic                 keep_mm;
   logic                 keep_f;
   logic [MM_NUM_W-1:0]  mm_num;
   logic [MM_PROD_W-1:0] mm_prod_in, mm_prod_ff;
   logic [7:0]           f_exp;
   logic [3:0]           f_shift;
   logic [24:0]          f_sum;
   logic [24:0]          f_quo;
   logic [DEPTH_W-1:0]   fdepth_in, fdepth_ff;
   logic [DIFF_W-1:0]    dx_in, dx_ff;
   logic [DIFF_W-1:0]    dy_in, dy_ff;
   logic [DEPTH_W-1:0]   depth_sel;
   logic signed [NUM_W:0] prod_x, prod_y;
   logic signed [NUM_W-1:0] num_x_in, num_x_ff;
   logic signed [NUM_W-1:0] num_y_in, num_y_ff;
   logic [DEPTH_W-1:0]   depth_ff;

   // stage 0: range check and depth conversion
   always_comb begin
      mm      = depth_raw[15:0];
      keep_mm = (mm > MM_LOW) && (mm < MM_HIGH);
      // unsigned compare on the pattern drops NaN, infinity, zero and negatives
      keep_f  = !depth_raw[RAW_W-1] && (depth_raw > F32_LOW) && (depth_raw < F32_HIGH);
      keep    = cfg.depth_fmt ? keep_f : keep_mm;

      mm_num     = {mm[12:0], 16'd0} + MM_ROUND;
      mm_prod_in = MM_PROD_W'(mm_num) * MM_PROD_W'(MM_RECIP);

      f_exp     = depth_raw[30:23];
      f_shift   = 4'(F32_SHIFT_BASE - f_exp);
      f_sum     = {1'b1, depth_raw[22:0]} + (25'd1 << (f_shift - 4'd1));
      f_quo     = f_sum >> f_shift;
      fdepth_in = f_quo[DEPTH_W-1:0];

      dx_in = DIFF_W'({col, 1'b0}) - DIFF_W'(cfg.cx);
      dy_in = DIFF_W'({row, 1'b0}) - DIFF_W'(cfg.cy);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mm_prod_ff <= mm_prod_in;
         fdepth_ff  <= fdepth_in;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
      end
   end

   // stage 1: pick the depth and scale the pixel offsets
   always_comb begin
      depth_sel = cfg.depth_fmt ? fdepth_ff : mm_prod_ff[MM_SHIFT +: DEPTH_W];
      prod_x    = $signed(dx_ff) * $signed({1'b0, depth_sel});
      prod_y    = $signed(dy_ff) * $signed({1'b0, depth_sel});
      num_x_in  = prod_x[NUM_W-1:0];
      num_y_in  = prod_y[NUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         num_x_ff <= num_x_in;
         num_y_ff <= num_y_in;
         depth_ff <= depth_sel;
      end
   end

   assign num_x = num_x_ff;
   assign num_y = num_y_ff;
   assign depth = depth_ff;

endmodule

### src/dpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_div: rounded division by 1050
// Stage 2 estimates |num| / 1050 by a reciprocal multiply; stage 3 corrects
// the estimate by one and restores the sign.
// ----------------------------------------------------------------------------
module dpw_div
   import dpw_pkg::*;
(
   input  logic                    clock,
   input  logic [1:0]              adv,
   input  logic signed [NUM_W-1:0] num_x,
   input  logic signed [NUM_W-1:0] num_y,
   input  logic [DEPTH_W-1:0]      depth,
   output logic signed [PNT_W-1:0] pnt_x,
   output logic signed [PNT_W-1:0] pnt_y,
   output logic [DEPTH_W-1:0]      pnt_z
);

   logic signed [NUM_W-1:0] num [2];
   logic [NUM_W-1:0]  mag [2];
   logic [MAG_W-1:0]  a_in [2];
   logic [MAG_W-1:0]  a_ff [2];
   logic [EST_W-1:0]  est_prod [2];
   logic [QUO_W-1:0]  est_in [2];
   logic [QUO_W-1:0]  est_ff [2];
   logic              neg_in [2];
   logic              neg_ff [2];
   logic [DEPTH_W-1:0] d2_ff;
   logic [MAG_W:0]    rem [2];
   logic [QUO_W-1:0]  quo [2];
   logic [PNT_W-1:0]  mquo [2];
   logic signed [PNT_W-1:0] pnt_in [2];
   logic signed [PNT_W-1:0] pnt_ff [2];
   logic [DEPTH_W-1:0] d3_ff;

   assign num[0] = num_x;
   assign num[1] = num_y;

   // stage 2: magnitude plus half divisor, then reciprocal estimate
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         neg_in[i]   = num[i][NUM_W-1];
         mag[i]      = neg_in[i] ? -num[i] : num[i];
         a_in[i]     = mag[i][MAG_W-1:0] + MAG_W'(DIV_HALF);
         est_prod[i] = EST_W'(a_in[i][MAG_W-1:MAG_W-QUO_W]) * EST_W'(DIV_RECIP);
         est_in[i]   = est_prod[i][DIV_SHIFT +: QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 2; i++) begin
            a_ff[i]   <= a_in[i];
            est_ff[i] <= est_in[i];
            neg_ff[i] <= neg_in[i];
         end
         d2_ff <= depth;
      end
   end

   // stage 3: estimate is exact or one short; fix it and apply the sign
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rem[i]    = {1'b0, a_ff[i]} - (MAG_W + 1)'(est_ff[i]) * (MAG_W + 1)'(DIV_CONST);
         quo[i]    = est_ff[i] + QUO_W'(rem[i] >= (MAG_W + 1)'(DIV_CONST));
         mquo[i]   = {1'b0, quo[i]};
         pnt_in[i] = neg_ff[i] ? PNT_W'(0) - mquo[i] : mquo[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < 2; i++) begin
            pnt_ff[i] <= pnt_in[i];
         end
         d3_ff <= d2_ff;
      end
   end

   assign pnt_x = pnt_ff[0];
   assign pnt_y = pnt_ff[1];
   assign pnt_z = d3_ff;

endmodule

### src/dpw_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_xform: rigid transform to world coordinates
// Stage 4 forms the nine rotation products; stage 5 sums them with the
// translation, rounds to 1/1024 m and saturates.
// ----------------------------------------------------------------------------
module dpw_xform
   import dpw_pkg::*;
(
   input  logic                    clock,
   input  logic [1:0]              adv,
   input  cfg_type                 cfg,
   input  logic signed [PNT_W-1:0] pnt_x,
   input  logic signed [PNT_W-1:0] pnt_y,
   input  logic [DEPTH_W-1:0]      pnt_z,
   output logic signed [OUT_W-1:0] world_x,
   output logic signed [OUT_W-1:0] world_y,
   output logic signed [OUT_W-1:0] world_z
);

   logic signed [PNT_W-1:0]  pnt [3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [ACC_W-1:0]  t_ext [3];
   logic signed [ACC_W-1:0]  acc [3];
   logic [2:0]               acc_top [3];
   logic signed [OUT_W-1:0]  world_in [3];
   logic signed [OUT_W-1:0]  world_ff [3];

   assign pnt[0] = pnt_x;
   assign pnt[1] = pnt_y;
   assign pnt[2] = {{(PNT_W - DEPTH_W){1'b0}}, pnt_z};

   // stage 4: R * p, one product per matrix entry
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(cfg.rot[i][j]) * pnt[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= prod_in[i][j];
            end
         end
      end
   end

   // stage 5: add translation, round half up, saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_ext[i]   = $signed(cfg.trans[i]);
         acc[i]     = prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2]
                      + (t_ext[i] <<< FRAC_SHIFT) + ROUND_HALF;
         acc_top[i] = acc[i][ACC_W-1:FRAC_SHIFT+OUT_W-1];
         if ((acc_top[i] == 3'b000) || (acc_top[i] == 3'b111)) begin
            world_in[i] = acc[i][FRAC_SHIFT +: OUT_W];
         end else if (acc[i][ACC_W-1]) begin
            world_in[i] = OUT_MIN;
         end else begin
            world_in[i] = OUT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            world_ff[i] <= world_in[i];
         end
      end
   end

   assign world_x = world_ff[0];
   assign world_y = world_ff[1];
   assign world_z = world_ff[2];

endmodule

### src/depth_pixel_to_world_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point: depth pixel back-projection and rigid transform
// Six register stages, the first loaded at the accepting edge, the last
// driving rsp_tvalid. Throughput: one item per cycle unless rsp_tready is low;
// each stage holds one multiply or one wide sum.
// A dropped pixel frees its slot at stage 0 and yields no result.
// Reset clears the stage valid bits and loads identity rotation, zero
// translation, principal point (320, 240), millimetre depth, pose not valid.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point
   import dpw_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  logic        clock,
   input  logic        reset,
   // request: pixel_col [11:0], pixel_row [23:12], depth_raw [55:24]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // response: world_x [23:0], world_y [47:24], world_z [71:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [62:0] csr_wdata
);

   localparam int COORD_USED = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
   localparam logic [COL_W-1:0] COL_MASK = COL_W'((64'd1 << COORD_USED) - 64'd1);

   logic [3*ROT_W-1:0]   rot_row_ff [3];
   logic [3*TRANS_W-1:0] trans_ff;
   logic [2*PP_W-1:0]    pp_ff;
   logic                 depth_fmt_ff;
   logic                 pose_valid_ff;
   cfg_type              cfg;

   logic [NUM_STAGES-1:0] v_ff, v_in;
   logic [NUM_STAGES-1:0] stg_en;

   logic [COL_W-1:0]        pix_col;
   logic [COL_W-1:0]        pix_row;
   logic [RAW_W-1:0]        depth_raw;
   logic                    keep;
   logic signed [NUM_W-1:0] num_x, num_y;
   logic [DEPTH_W-1:0]      depth;
   logic signed [PNT_W-1:0] pnt_x, pnt_y;
   logic [DEPTH_W-1:0]      pnt_z;
   logic signed [OUT_W-1:0] world_x, world_y, world_z;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= 48'h0000_0000_4000;
         rot_row_ff[1] <= 48'h0000_4000_0000;
         rot_row_ff[2] <= 48'h4000_0000_0000;
         trans_ff      <= '0;
         pp_ff         <= 28'd7864960;
         depth_fmt_ff  <= 1'b0;
         pose_valid_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_ROW_0:   rot_row_ff[0] <= csr_wdata[3*ROT_W-1:0];
            CSR_ROT_ROW_1:   rot_row_ff[1] <= csr_wdata[3*ROT_W-1:0];
            CSR_ROT_ROW_2:   rot_row_ff[2] <= csr_wdata[3*ROT_W-1:0];
            CSR_TRANSLATION: trans_ff      <= csr_wdata[3*TRANS_W-1:0];
            CSR_PRINCIPAL:   pp_ff         <= csr_wdata[2*PP_W-1:0];
            CSR_DEPTH_FMT:   depth_fmt_ff  <= csr_wdata[0];
            CSR_POSE_VALID:  pose_valid_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.rot[0]     = rot_row_ff[0];
      cfg.rot[1]     = rot_row_ff[1];
      cfg.rot[2]     = rot_row_ff[2];
      cfg.trans      = trans_ff;
      cfg.cx         = pp_ff[PP_W-1:0];
      cfg.cy         = pp_ff[2*PP_W-1:PP_W];
      cfg.depth_fmt  = depth_fmt_ff;
      cfg.pose_valid = pose_valid_ff;
   end

   // a stage advances when it is empty or the stage after it advances
   always_comb begin
      stg_en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stg_en[i] = !v_ff[i] || stg_en[i+1];
      end
      v_in[0] = req_tvalid && cfg.pose_valid && keep;
      for (int i = 1; i < NUM_STAGES; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stg_en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign pix_col   = req_tdata[COL_W-1:0] & COL_MASK;
   assign pix_row   = req_tdata[2*COL_W-1:COL_W] & COL_MASK;
   assign depth_raw = req_tdata[2*COL_W +: RAW_W];

   dpw_depth u_depth (
      .clock     (clock),
      .adv       (stg_en[1:0]),
      .cfg       (cfg),
      .col       (pix_col),
      .row       (pix_row),
      .depth_raw (depth_raw),
      .keep      (keep),
      .num_x     (num_x),
      .num_y     (num_y),
      .depth     (depth)
   );

   dpw_div u_div (
      .clock (clock),
      .adv   (stg_en[3:2]),
      .num_x (num_x),
      .num_y (num_y),
      .depth (depth),
      .pnt_x (pnt_x),
      .pnt_y (pnt_y),
      .pnt_z (pnt_z)
   );

   dpw_xform u_xform (
      .clock   (clock),
      .adv     (stg_en[5:4]),
      .cfg     (cfg),
      .pnt_x   (pnt_x),
      .pnt_y   (pnt_y),
      .pnt_z   (pnt_z),
      .world_x (world_x),
      .world_y (world_y),
      .world_z (world_z)
   );

   assign req_tready = stg_en[0];
   assign rsp_tvalid = v_ff[NUM_STAGES-1];
   assign rsp_tdata  = {world_z, world_y, world_x};

   // no pose: an accepted pixel never enters the pipeline
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !cfg.pose_valid |=> !v_ff[0])
      else $error("pixel entered pipeline without a valid pose");

   // millimetre depth at or below the near limit is dropped
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !cfg.depth_fmt && (depth_raw[15:0] <= MM_LOW)
      |=> !v_ff[0])
      else $error("near millimetre depth was not dropped");

   // input backs up only when every stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&v_ff))
      else $error("input stalled with an empty stage");

   // a held last stage stays full and the stage before it keeps its item
   assert property (@(posedge clock) disable iff (reset)
      v_ff[NUM_STAGES-2] && !stg_en[NUM_STAGES-1]
      |=> v_ff[NUM_STAGES-2] && v_ff[NUM_STAGES-1])
      else $error("item lost while output stalled");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: depth pixel to world point testbench
// Streams depth pixels through the block under several camera poses, both
// depth formats and the extreme register values. Each accepted pixel has a
// given result or is projected in a local integer model; every world point
// out is compared axis by axis with the oldest pending result. Both ports
// idle at random, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------
module tb;
   import dpw_pkg::*;

   localparam int          COORD_BITS   = 12;
   localparam logic [11:0] COORD_MASK   = 12'((1 << COORD_BITS) - 1);
   localparam logic [2:0]  CSR_UNMAPPED = 3'd7;
   localparam int          NUM_PROBES   = 24;
   localparam int          NUM_PHASES   = 8;
   localparam int          PHASE_ITEMS  = 68;
   localparam int          SETTLE       = NUM_STAGES + 4;

   // camera pose and depth setup, laid out as the registers hold it
   typedef struct packed {
      logic [2:0][47:0] rot;
      logic [62:0]      trans;
      logic [27:0]      pp;
      logic             fmt;
      logic             pose;
   } pose_cfg_type;

   typedef struct packed {
      logic        fmt;
      logic        pose;
      logic [11:0] col;
      logic [11:0] row;
      logic [31:0] raw;
      logic        typed;   // expectation given in the row
      logic        keep;
      logic [71:0] world;   // z, y, x from the top
   } probe_row_type;

   localparam logic [71:0] ONE_METER = {24'd1024, 24'd0, 24'd0};
   localparam logic [71:0] NO_POINT  = '0;

   localparam pose_cfg_type RESET_CFG = '{
      rot:   {48'd16384 << 32, 48'd16384 << 16, 48'd16384},
      trans: 63'd0,
      pp:    28'd7864960,
      fmt:   1'b0,
      pose:  1'b0
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // pixel_col [11:0], pixel_row [23:12], depth_raw [55:24]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // world_x [23:0], world_y [47:24], world_z [71:48]
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [62:0] csr_wdata;

   pose_cfg_type cur_cfg;
   logic [71:0] world_q [$];
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int          hold_left;
   int          errors;
   int          points_seen;
   int          pixels_sent;
   int          pixels_dropped;
   int          cfg_loads;

   probe_row_type probes [NUM_PROBES] = '{
      // pose not loaded yet
      '{1'b0, 1'b0, 12'd320,  12'd240,  32'd1000,       1'b1, 1'b0, NO_POINT},
      // millimeters, pixels on the optical axis and at the corners
      '{1'b0, 1'b1, 12'd320,  12'd240,  32'd1000,       1'b1, 1'b1, ONE_METER},
      '{1'b0, 1'b1, 12'd320,  12'd240,  32'hFFFF_03E8,  1'b1, 1'b1, ONE_METER},
      '{1'b0, 1'b1, 12'd320,  12'd240,  32'd200,        1'b1, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd320,  12'd240,  32'd5000,       1'b1, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd0,    12'd0,    32'd0,          1'b1, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd4095, 12'd4095, 32'h0000_FFFF,  1'b1, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd0,    12'd0,    32'd201,        1'b0, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd4095, 12'd4095, 32'd4999,       1'b0, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd4095, 12'd0,    32'd2500,       1'b0, 1'b0, NO_POINT},
      '{1'b0, 1'b1, 12'd0,    12'd4095, 32'hA5A5_0BB8,  1'b0, 1'b0, NO_POINT},
      // float meters
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'h3F80_0000,  1'b1, 1'b1, ONE_METER},
      '{1'b1, 1'b1, 12'd320,  12'd240,  F32_LOW,        1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  F32_HIGH,       1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd0,    12'd0,    32'h3E4C_CCCE,  1'b0, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd4095, 12'd4095, 32'h409F_FFFF,  1'b0, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'h7FC0_0000,  1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'h7F80_0000,  1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'h0000_0000,  1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'hBF80_0000,  1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'hFFFF_FFFF,  1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd320,  12'd240,  32'h8000_0000,  1'b1, 1'b0, NO_POINT},
      '{1'b1, 1'b1, 12'd100,  12'd3000, 32'h4000_0000,  1'b0, 1'b0, NO_POINT},
      // pose dropped again
      '{1'b1, 1'b0, 12'd320,  12'd240,  32'h3F80_0000,  1'b1, 1'b0, NO_POINT}
   };

   depth_pixel_to_world_point #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // rounded to nearest, ties away from zero
   function automatic longint round_div_1050(input longint num);
      if (num >= 0)
         return (num + 525) / 1050;
      return -((-num + 525) / 1050);
   endfunction

   function automatic bit project_pixel(input logic [55:0] item, output logic [71:0] world);
      longint      u, v, d, cx, cy, acc, q;
      longint      pnt [3];
      logic [31:0] raw;
      logic [23:0] mant;
      int          sh;
      world = '0;
      u     = longint'(item[11:0] & COORD_MASK);
      v     = longint'(item[23:12] & COORD_MASK);
      raw   = item[55:24];
      if (!cur_cfg.pose)
         return 1'b0;
      if (!cur_cfg.fmt) begin
         if (raw[15:0] <= MM_LOW || raw[15:0] >= MM_HIGH)
            return 1'b0;
         d = (longint'(raw[15:0]) * 65536 + 500) / 1000;
      end else begin
         // the open interval also rejects NaN, infinity, zero and negatives
         if (raw[31] || raw <= F32_LOW || raw >= F32_HIGH)
            return 1'b0;
         sh   = int'(F32_SHIFT_BASE) - int'(raw[30:23]);
         mant = {1'b1, raw[22:0]};
         d    = (longint'(mant) + (longint'(1) << (sh - 1))) >> sh;
      end
      cx     = longint'(cur_cfg.pp[13:0]);
      cy     = longint'(cur_cfg.pp[27:14]);
      pnt[0] = round_div_1050((2 * u - cx) * d);
      pnt[1] = round_div_1050((2 * v - cy) * d);
      pnt[2] = d;
      for (int i = 0; i < 3; i++) begin
         acc = longint'($signed(cur_cfg.trans[21*i +: 21])) * 1048576;
         for (int j = 0; j < 3; j++)
            acc += longint'($signed(cur_cfg.rot[i][16*j +: 16])) * pnt[j];
         q = (acc + 524288) >>> 20;
         if (q > 8388607)
            q = 8388607;
         if (q < -8388608)
            q = -8388608;
         world[24*i +: 24] = q[23:0];
      end
      return 1'b1;
   endfunction

   function automatic void check_world_point(input logic [71:0] got);
      logic [71:0] want;
      if (world_q.size() == 0) begin
         errors++;
         $display("%0t: world point %h arrived with nothing pending", $time, got);
         return;
      end
      want = world_q.pop_front();
      points_seen++;
      for (int i = 0; i < 3; i++)
         if (got[24*i +: 24] !== want[24*i +: 24]) begin
            errors++;
            $display("%0t: axis %0d mismatch: expected %0d, got %0d", $time, i,
                     $signed(want[24*i +: 24]), $signed(got[24*i +: 24]));
         end
   endfunction

   function automatic logic [11:0] pick_coord();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_depth(input logic fmt);
      logic [31:0] w;
      w = $urandom;
      if (fmt) begin
         case ($urandom_range(9))
            0: ;
            // NaN or infinity, or a negative value
            1: w = $urandom_range(1) ? (32'h7F80_0000 | (w & 32'h807F_FFFF))
                                     : (32'h8000_0000 | w);
            default: w = $urandom_range(F32_HIGH - 1, F32_LOW + 1);
         endcase
      end else begin
         case ($urandom_range(9))
            0: ;
            1: w[15:0] = $urandom_range(1) ? MM_LOW : MM_HIGH;
            default: w[15:0] = 16'($urandom_range(MM_HIGH - 1, MM_LOW + 1));
         endcase
      end
      return w;
   endfunction

   function automatic pose_cfg_type random_cfg(input logic fmt, input logic pose);
      pose_cfg_type c;
      for (int i = 0; i < 3; i++)
         c.rot[i] = 48'({$urandom, $urandom});
      c.trans = 63'({$urandom, $urandom});
      c.pp    = 28'($urandom);
      c.fmt   = fmt;
      c.pose  = pose;
      return c;
   endfunction

   // bits above the register width carry junk and must be ignored
   task automatic put_csr(input logic [2:0] idx, input logic [62:0] val, input int width);
      logic [62:0] junk;
      logic [62:0] mask;
      junk = 63'({$urandom, $urandom});
      mask = (63'd1 << width) - 63'd1;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (val & mask) | (junk & ~mask);
      @(posedge clock);
   endtask

   task automatic write_config(input pose_cfg_type c);
      put_csr(CSR_ROT_ROW_0, 63'(c.rot[0]), 48);
      put_csr(CSR_ROT_ROW_1, 63'(c.rot[1]), 48);
      put_csr(CSR_ROT_ROW_2, 63'(c.rot[2]), 48);
      put_csr(CSR_TRANSLATION, c.trans, 63);
      put_csr(CSR_PRINCIPAL, 63'(c.pp), 28);
      put_csr(CSR_DEPTH_FMT, 63'(c.fmt), 1);
      put_csr(CSR_POSE_VALID, 63'(c.pose), 1);
      // unmapped index: nothing may change
      put_csr(CSR_UNMAPPED, '0, 0);
      csr_we  <= 1'b0;
      cur_cfg  = c;
      cfg_loads++;
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (world_q.size() != 0)
         @(posedge clock);
      // dropped pixels never enter the pipeline; the pause only lets it settle
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [55:0] item, input logic typed, input logic keep,
                             input logic [71:0] given);
      logic [71:0] world;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (typed) begin
         if (keep)
            world_q = {world_q, given};
         else
            pixels_dropped++;
      end else if (project_pixel(item, world)) begin
         world_q = {world_q, world};
      end else begin
         pixels_dropped++;
      end
   endtask

   // output side: check, then decide the next cycle's ready
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_world_point(rsp_tdata);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      pose_cfg_type c;
      int        mode;
      int        count;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_ROT_ROW_0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      errors         = 0;
      points_seen    = 0;
      pixels_sent    = 0;
      pixels_dropped = 0;
      cfg_loads      = 0;
      cur_cfg        = RESET_CFG;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[k]) begin
         if (probes[k].fmt != cur_cfg.fmt || probes[k].pose != cur_cfg.pose) begin
            drain_pipeline();
            c      = cur_cfg;
            c.fmt  = probes[k].fmt;
            c.pose = probes[k].pose;
            write_config(c);
         end
         send_pixel({probes[k].raw, probes[k].row, probes[k].col},
                    probes[k].typed, probes[k].keep, probes[k].world);
      end
      drain_pipeline();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               c      = RESET_CFG;
               c.pose = 1'b1;
            end
            2: c = '{rot: {3{{3{16'h8000}}}}, trans: {3{21'h10_0000}}, pp: '0,
                     fmt: 1'b0, pose: 1'b1};
            3: c = '{rot: {3{{3{16'h7FFF}}}}, trans: {3{21'h0F_FFFF}}, pp: '1,
                     fmt: 1'b1, pose: 1'b1};
            5: c = random_cfg(1'($urandom), 1'b0);
            default: c = random_cfg(1'($urandom), 1'b1);
         endcase
         write_config(c);
         mode           = ph % 4;
         send_idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 11 : 0;
         recv_stall_pct = (mode == 2) ? 47 : (mode == 3) ? 11 : 0;
         // back the pipeline up while the input keeps offering items
         if (ph == 4)
            hold_left = 120;
         count = (ph == 5) ? 20 : PHASE_ITEMS;
         repeat (count)
            send_pixel({pick_depth(cur_cfg.fmt), pick_coord(), pick_coord()},
                       1'b0, 1'b0, NO_POINT);
         drain_pipeline();
      end

      $display("Sent %0d pixels under %0d register setups, both depth formats.",
               pixels_sent, cfg_loads);
      $display("Checked %0d world points, %0d pixels dropped, %0d errors.",
               points_seen, pixels_dropped, errors);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
src/dpw_pkg.sv
src/dpw_depth.sv
src/dpw_div.sv
src/dpw_xform.sv
src/depth_pixel_to_world_point.sv
bench/tb.sv
